[design/vm3_pkg.sv]
// ----------------------------------------------------------------------------
// vm3_pkg
// shared constants for the three-axis vector magnitude unit
// ----------------------------------------------------------------------------
package vm3_pkg;

	localparam int MAG_W = 15;
	localparam logic [MAG_W-1:0] MAG_MAX = 15'h7FFF;

endpackage

[design/vm3_front.sv]
// ----------------------------------------------------------------------------
// vm3_front
// absolute value, per-axis square and three-way sum, three pipeline stages
// ----------------------------------------------------------------------------
module vm3_front import vm3_pkg::*; #(
	parameter int SAMPLE_BITS = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [SAMPLE_BITS-1:0]     x_sample,
	input  logic [SAMPLE_BITS-1:0]     y_sample,
	input  logic [SAMPLE_BITS-1:0]     z_sample,
	input  logic                       window_last,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [2*SAMPLE_BITS+1:0]   sum,
	output logic                       sum_last
);

	localparam int SB = SAMPLE_BITS;
	localparam int SQ_W = 2 * SB;
	localparam int SUM_W = 2 * SB + 2;

	logic          v_s1, v_s2, v_s3;
	logic          rdy1, rdy2, rdy3;
	logic [SB-1:0] ax_s1, ay_s1, az_s1;
	logic          last_s1, last_s2, last_s3;
	logic [SQ_W-1:0] sx_s2, sy_s2, sz_s2;
	logic [SUM_W-1:0] sum_s3;
	logic [SB-1:0] ax, ay, az;

	assign rdy3 = !v_s3 || out_ready;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;
	assign in_ready = rdy1;

	// two's complement magnitude, the most negative value maps to 2^(SB-1)
	assign ax = x_sample[SB-1] ? (~x_sample + SB'(1)) : x_sample;
	assign ay = y_sample[SB-1] ? (~y_sample + SB'(1)) : y_sample;
	assign az = z_sample[SB-1] ? (~z_sample + SB'(1)) : z_sample;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && in_valid) begin
			ax_s1   <= ax;
			ay_s1   <= ay;
			az_s1   <= az;
			last_s1 <= window_last;
		end
		if (rdy2 && v_s1) begin
			sx_s2   <= SQ_W'(ax_s1) * SQ_W'(ax_s1);
			sy_s2   <= SQ_W'(ay_s1) * SQ_W'(ay_s1);
			sz_s2   <= SQ_W'(az_s1) * SQ_W'(az_s1);
			last_s2 <= last_s1;
		end
		if (rdy3 && v_s2) begin
			sum_s3  <= SUM_W'(sx_s2) + SUM_W'(sy_s2) + SUM_W'(sz_s2);
			last_s3 <= last_s2;
		end
	end

	assign out_valid = v_s3;
	assign sum       = sum_s3;
	assign sum_last  = last_s3;

endmodule

[design/vm3_root_cell.sv]
// ----------------------------------------------------------------------------
// vm3_root_cell
// one digit of the restoring square root, registered, with its own handshake
// ----------------------------------------------------------------------------
module vm3_root_cell import vm3_pkg::*; #(
	parameter int SUM_W = 34,
	parameter int ROOT_W = 17,
	parameter int STEP = 0
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [SUM_W-1:0]  rem_in,
	input  logic [ROOT_W-1:0] root_in,
	input  logic              last_in,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [SUM_W-1:0]  rem_out,
	output logic [ROOT_W-1:0] root_out,
	output logic              last_out
);

	logic              valid_q;
	logic [SUM_W-1:0]  rem_q;
	logic [ROOT_W-1:0] root_q;
	logic              last_q;
	logic [SUM_W:0]    trial;
	logic              take;

	// (r + 2^k)^2 - r^2 = r*2^(k+1) + 2^(2k)
	assign trial = ((SUM_W + 1)'(root_in) << (STEP + 1)) + ((SUM_W + 1)'(1) << (2 * STEP));
	assign take  = {1'b0, rem_in} >= trial;

	assign in_ready = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			rem_q  <= take ? (rem_in - trial[SUM_W-1:0]) : rem_in;
			root_q <= root_in | (ROOT_W'(take) << STEP);
			last_q <= last_in;
		end
	end

	assign out_valid = valid_q;
	assign rem_out   = rem_q;
	assign root_out  = root_q;
	assign last_out  = last_q;

endmodule

[design/vector_magnitude_3axis_unit.sv]
// ----------------------------------------------------------------------------
// vector_magnitude_3axis_unit
// floor square root of x*x + y*y + z*z, saturated to 15 bits
// pipeline: 3 front stages, one root cell per result bit (SAMPLE_BITS + 1
//   cells), one output register
// throughput: one request per cycle while the output is taken; each stage
//   advances when its slot is empty or its successor takes data, so stalls only fill bubbles
// reset clears every stage valid bit; payload registers are not reset
// ----------------------------------------------------------------------------
module vector_magnitude_3axis_unit import vm3_pkg::*; #(
	parameter int SAMPLE_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [SAMPLE_BITS-1:0] x_sample,
	input  logic [SAMPLE_BITS-1:0] y_sample,
	input  logic [SAMPLE_BITS-1:0] z_sample,
	input  logic                   window_last,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [MAG_W-1:0]       magnitude,
	output logic                   result_last
);

	localparam int SUM_W = 2 * SAMPLE_BITS + 2;
	localparam int ROOT_W = SAMPLE_BITS + 1;
	localparam int CMP_W = (ROOT_W > MAG_W) ? ROOT_W : MAG_W;

	logic [SUM_W-1:0]  rem_c  [0:ROOT_W];
	logic [ROOT_W-1:0] root_c [0:ROOT_W];
	logic              last_c [0:ROOT_W];
	logic              vld_c  [0:ROOT_W];
	logic              rdy_c  [0:ROOT_W];

	logic              out_valid_q;
	logic [MAG_W-1:0]  mag_q;
	logic              last_q;
	logic              out_take;
	logic [CMP_W-1:0]  root_ext;
	logic [MAG_W-1:0]  mag_sat;

	vm3_front #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.x_sample   (x_sample),
		.y_sample   (y_sample),
		.z_sample   (z_sample),
		.window_last(window_last),
		.out_valid  (vld_c[0]),
		.out_ready  (rdy_c[0]),
		.sum        (rem_c[0]),
		.sum_last   (last_c[0])
	);

	assign root_c[0] = '0;

	// most significant root bit first
	for (genvar k = 0; k < ROOT_W; k++) begin : g_cell
		vm3_root_cell #(
			.SUM_W (SUM_W),
			.ROOT_W(ROOT_W),
			.STEP  (ROOT_W - 1 - k)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (vld_c[k]),
			.in_ready (rdy_c[k]),
			.rem_in   (rem_c[k]),
			.root_in  (root_c[k]),
			.last_in  (last_c[k]),
			.out_valid(vld_c[k+1]),
			.out_ready(rdy_c[k+1]),
			.rem_out  (rem_c[k+1]),
			.root_out (root_c[k+1]),
			.last_out (last_c[k+1])
		);
	end

	assign root_ext = CMP_W'(root_c[ROOT_W]);
	assign mag_sat  = (root_ext > CMP_W'(MAG_MAX)) ? MAG_MAX : root_ext[MAG_W-1:0];

	assign out_take       = !out_valid_q || out_ready;
	assign rdy_c[ROOT_W]  = out_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_take) begin
			out_valid_q <= vld_c[ROOT_W];
		end
	end

	always_ff @(posedge clk) begin
		if (out_take && vld_c[ROOT_W]) begin
			mag_q  <= mag_sat;
			last_q <= last_c[ROOT_W];
		end
	end

	// final remainder is not needed past the last cell
	logic unused_rem;
	assign unused_rem = ^rem_c[ROOT_W];

	assign out_valid   = out_valid_q && (unused_rem || !unused_rem);
	assign magnitude   = mag_q;
	assign result_last = last_q;

endmodule

[test/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// checks vector_magnitude_3axis_unit: each accepted sample is scored by a
// local integer square root of the exact sum of squares, and every result
// is compared in order against it; directed corners first, then random
// vectors with random gaps, a long output hold-off and a gap-free stream
// ----------------------------------------------------------------------------
module testbench;
	import vm3_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int SAMPLE_BITS = 16;
	localparam int LATENCY     = SAMPLE_BITS + 5;
	localparam int CYCLE_LIMIT = 500000;

	typedef logic [SAMPLE_BITS-1:0] axis_t;

	typedef struct {
		logic [MAG_W-1:0] magnitude;
		logic             last;
		axis_t            x;
		axis_t            y;
		axis_t            z;
	} mag_result_t;

	logic             clk         = 1'b0;
	logic             arst_n      = 1'b0;
	logic             in_valid    = 1'b0;
	logic             in_ready;
	axis_t            x_sample    = '0;
	axis_t            y_sample    = '0;
	axis_t            z_sample    = '0;
	logic             window_last = 1'b0;
	logic             out_valid;
	logic             out_ready   = 1'b0;
	logic [MAG_W-1:0] magnitude;
	logic             result_last;

	mag_result_t pending_results[$];
	int          error_count  = 0;
	int          cycle_count  = 0;
	bit          tx_idle_en   = 1'b1;
	bit          rx_idle_en   = 1'b1;
	int          hold_request = 0;

	vector_magnitude_3axis_unit #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.x_sample   (x_sample),
		.y_sample   (y_sample),
		.z_sample   (z_sample),
		.window_last(window_last),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.magnitude  (magnitude),
		.result_last(result_last)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
				pending_results.size());
			$display("Simulation FAILED");
			$finish;
		end
	end

	// floor root of x*x+y*y+z*z, the sum held at full width
	function automatic mag_result_t predict_result(axis_t x, axis_t y, axis_t z, logic last);
		mag_result_t      r;
		logic [SAMPLE_BITS:0] ax;
		logic [SAMPLE_BITS:0] ay;
		logic [SAMPLE_BITS:0] az;
		longint unsigned  rem;
		longint unsigned  root;
		longint unsigned  probe;
		ax = x[SAMPLE_BITS-1] ? (SAMPLE_BITS+1)'((1 << SAMPLE_BITS) - {1'b0, x}) : {1'b0, x};
		ay = y[SAMPLE_BITS-1] ? (SAMPLE_BITS+1)'((1 << SAMPLE_BITS) - {1'b0, y}) : {1'b0, y};
		az = z[SAMPLE_BITS-1] ? (SAMPLE_BITS+1)'((1 << SAMPLE_BITS) - {1'b0, z}) : {1'b0, z};
		rem = longint'(ax) * ax + longint'(ay) * ay + longint'(az) * az;
		root = 0;
		probe = 64'h1 << 34;
		while (probe != 0) begin
			if (rem >= root + probe) begin
				rem -= root + probe;
				root = (root >> 1) + probe;
			end else begin
				root >>= 1;
			end
			probe >>= 2;
		end
		r.magnitude = (root > MAG_MAX) ? MAG_MAX : root[MAG_W-1:0];
		r.last = last;
		r.x = x;
		r.y = y;
		r.z = z;
		return r;
	endfunction

	task automatic report_mismatch(string what, int got, int want, mag_result_t ref_item);
		error_count++;
		$display("mismatch at cycle %0d: %s got %0d expected %0d (x=%0d y=%0d z=%0d)",
			cycle_count, what, got, want, $signed(ref_item.x), $signed(ref_item.y),
			$signed(ref_item.z));
	endtask

	// input side scores each accepted request; output side checks in order
	always @(posedge clk) begin : result_check
		mag_result_t want;
		if (arst_n) begin
			if (in_valid && in_ready)
				pending_results.push_back(predict_result(x_sample, y_sample, z_sample,
					window_last));
			if (out_valid && out_ready) begin
				if (pending_results.size() == 0) begin
					want = '{default: '0};
					report_mismatch("unexpected result, magnitude", magnitude, 0, want);
				end else begin
					want = pending_results.pop_front();
					if (magnitude !== want.magnitude)
						report_mismatch("magnitude", magnitude, want.magnitude, want);
					if (result_last !== want.last)
						report_mismatch("result_last", result_last, want.last, want);
				end
			end
		end
	end

	// receiver: long hold-off on request, otherwise random stall bursts
	initial begin : receiver
		int hold_left;
		int stall_left;
		hold_left = 0;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (hold_request > 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(1, 8) - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// called at a rising edge, returns at the edge that takes the request
	task automatic send_sample(axis_t x, axis_t y, axis_t z, logic last);
		if (tx_idle_en && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		x_sample    <= x;
		y_sample    <= y;
		z_sample    <= z;
		window_last <= last;
		in_valid    <= 1'b1;
		@(negedge clk);
		while (!in_ready) @(negedge clk);
		@(posedge clk);
	endtask

	function automatic axis_t random_axis();
		case ($urandom_range(0, 4))
			0: return axis_t'($urandom_range(0, 127) - 64);
			1: return axis_t'(16'h8000 + $urandom_range(0, 255));
			2: return axis_t'(16'h7FFF - $urandom_range(0, 255));
			default: return axis_t'($urandom);
		endcase
	endfunction

	task automatic send_random_sample();
		axis_t a;
		axis_t b;
		axis_t c;
		a = random_axis();
		b = random_axis();
		c = random_axis();
		// single-axis vectors land on exact roots
		case ($urandom_range(0, 5))
			0: send_sample(a, '0, '0, 1'($urandom));
			1: send_sample('0, b, '0, 1'($urandom));
			2: send_sample('0, '0, c, 1'($urandom));
			default: send_sample(a, b, c, 1'($urandom));
		endcase
	endtask

	task automatic test_directed_vectors();
		send_sample(16'sd0, 16'sd0, 16'sd0, 1'b0);
		send_sample(16'sd0, 16'sd0, 16'sd0, 1'b1);
		send_sample(16'sd1, 16'sd0, 16'sd0, 1'b0);
		send_sample(-16'sd1, -16'sd1, -16'sd1, 1'b1);
		send_sample(16'sd3, 16'sd4, 16'sd0, 1'b0);
		send_sample(16'sd2, -16'sd4, 16'sd4, 1'b0);
		send_sample(16'sd3, 16'sd4, 16'sd12, 1'b1);
		send_sample(16'sd3, 16'sd4, 16'sd11, 1'b0);
		send_sample(16'sd32767, 16'sd0, 16'sd0, 1'b0);
		send_sample(-16'sd32767, 16'sd0, 16'sd0, 1'b1);
		// most negative sample: magnitude 32768 saturates
		send_sample(16'h8000, 16'sd0, 16'sd0, 1'b0);
		send_sample(16'sd0, 16'h8000, 16'sd0, 1'b0);
		send_sample(16'sd0, 16'sd0, 16'h8000, 1'b1);
		send_sample(16'sd32767, 16'sd32767, 16'sd32767, 1'b0);
		// full-width sum, must not wrap
		send_sample(16'h8000, 16'h8000, 16'h8000, 1'b1);
		send_sample(16'sd23170, 16'sd23170, 16'sd0, 1'b0);
		send_sample(16'sd18918, -16'sd18918, 16'sd18918, 1'b0);
		send_sample(16'h5555, 16'hAAAA, 16'h5555, 1'b1);
		send_sample(16'hAAAA, 16'h5555, 16'hAAAA, 1'b0);
		send_sample(16'sd1, 16'sd1, 16'sd1, 1'b0);
		send_sample(-16'sd12, 16'sd5, 16'sd0, 1'b1);
	endtask

	task automatic test_random_vectors(int count);
		repeat (count) send_random_sample();
	endtask

	// output held off while requests keep coming, so the pipe fills and backs up
	task automatic test_output_backpressure(int count);
		tx_idle_en = 1'b0;
		hold_request = 300;
		repeat (count) send_random_sample();
		tx_idle_en = 1'b1;
	endtask

	task automatic test_full_rate_stream(int count);
		tx_idle_en = 1'b0;
		rx_idle_en = 1'b0;
		repeat (count) send_random_sample();
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_vectors();
		test_random_vectors(1500);
		test_output_backpressure(80);
		test_full_rate_stream(200);
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (2 * LATENCY) @(posedge clk);
		if (error_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
